FILE: design/msbr_pkg.sv
`timescale 1ns / 1ps

package msbr_pkg;

  localparam int BUFFER_BYTES_DEF   = 4096;
  localparam int MAX_FIELD_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 12;
  localparam int POS_W   = 13;
  localparam int LEN_W   = 13;
  localparam int FIELD_W = 32;
  localparam int BITS_W  = 16;
  localparam int ROW_W   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_GET    = 3'd1,
    OP_SHOW   = 3'd2,
    OP_SKIP   = 3'd3,
    OP_ALIGN  = 3'd4,
    OP_REWIND = 3'd5
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] field_value;
    logic [POS_W-1:0]   pos;
    logic [2:0]         off;
  } exec_res_t;

endpackage

FILE: design/msbr_store.sv
`timescale 1ns / 1ps

module msbr_store import msbr_pkg::*; #(
  parameter int ROWS = BUFFER_BYTES_DEF / 8,
  parameter int RAW  = 9
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [RAW-1:0]   wr_row,
  input  logic [2:0]       wr_lane,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [RAW-1:0]   rd_row_a,
  input  logic [RAW-1:0]   rd_row_b,
  output logic [ROW_W-1:0] rd_data_a,
  output logic [ROW_W-1:0] rd_data_b
);

  // eight bytes per row, lane k holds byte address row*8+k
  logic [ROW_W-1:0] store_r [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_row][wr_lane*8 +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= store_r[rd_row_a];
      rd_data_b <= store_r[rd_row_b];
    end
  end

endmodule

FILE: design/msbr_exec.sv
`timescale 1ns / 1ps

module msbr_exec import msbr_pkg::*; #(
  parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  op_t              op,
  input  logic [CNT_W-1:0] count,
  input  logic [POS_W-1:0] pos,
  input  logic [2:0]       off,
  input  logic [LEN_W-1:0] len_raw,
  input  logic [ROW_W-1:0] row_a,
  input  logic [ROW_W-1:0] row_b,
  output exec_res_t        res
);

  logic [LEN_W-1:0]   len;
  logic [BITS_W-1:0]  cur;
  logic [BITS_W-1:0]  end_bits;
  logic [BITS_W-1:0]  avail;
  logic [5:0]         cnt;
  logic [5:0]         nread;
  logic [127:0]       win;
  logic [39:0]        w40;
  logic [39:0]        w40_sh;
  logic [FIELD_W-1:0] top;
  logic [FIELD_W-1:0] mask;
  logic [FIELD_W-1:0] val;
  logic [BITS_W-1:0]  get_end;
  logic [BITS_W:0]    skip_total;
  logic [BITS_W-3:0]  skip_byte;

  assign len = ({19'b0, len_raw} > 32'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES) : len_raw;

  assign cur      = {pos, off};
  assign end_bits = {len, 3'b000};
  assign avail    = (cur < end_bits) ? (end_bits - cur) : '0;

  assign cnt   = (count > CNT_W'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : count[5:0];
  assign nread = ({10'b0, cnt} > avail) ? avail[5:0] : cnt;

  // two rows laid out first byte at the top
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      win[127 - 8*k -: 8] = row_a[8*k +: 8];
      win[63 - 8*k -: 8]  = row_b[8*k +: 8];
    end
  end

  assign w40    = win[127 - 8*pos[2:0] -: 40];
  assign w40_sh = w40 << off;
  assign top    = w40_sh[39:8];

  // keep the bits actually read, zeros stand in past the end
  assign mask = ~({FIELD_W{1'b1}} >> nread);
  assign val  = (top & mask) >> (6'd32 - cnt);

  assign get_end    = cur + {10'b0, nread};
  assign skip_total = {1'b0, cur} + {1'b0, count};
  assign skip_byte  = skip_total[BITS_W:3];

  always_comb begin
    res.field_value = '0;
    res.pos         = pos;
    res.off         = off;
    unique case (op)
      OP_GET: begin
        res.field_value = val;
        res.pos         = get_end[BITS_W-1:3];
        res.off         = get_end[2:0];
      end
      OP_SHOW: begin
        res.field_value = val;
      end
      OP_SKIP: begin
        if (skip_byte >= {1'b0, len}) begin
          res.pos = len;
          res.off = 3'd0;
        end else begin
          res.pos = skip_byte[POS_W-1:0];
          res.off = skip_total[2:0];
        end
      end
      OP_ALIGN: begin
        if (off != 3'd0) begin
          res.pos = pos + POS_W'(1);
          res.off = 3'd0;
        end
      end
      OP_REWIND: begin
        res.pos = '0;
        res.off = 3'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/msb_first_bit_reader.sv
`timescale 1ns / 1ps

// MSB-first bit reader over a byte store held in one memory of 8-byte rows.
// Each item is accepted in S_IDLE: in the accept cycle the memory reads the row
// holding the current byte and the row after it (and a load writes its
// byte lane); in S_EXEC the field is extracted, the position moves and
// the result goes to the output register. S_EXEC waits while a result is
// not yet taken, and no next item is accepted until it moves on. The store
// needs no clearing after reset; bytes inside the buffer length must be
// loaded before they are read. cfg_wdata sets the buffer length in bytes
// and is to be written only while the reader is idle; no check enforces it.
module msb_first_bit_reader import msbr_pkg::*; #(
  parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [CNT_W-1:0]   in_bit_count,
  input  logic [ADDR_W-1:0]  in_byte_address,
  input  logic [7:0]         in_byte_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_field_value,
  output logic [BITS_W-1:0]  out_bits_consumed
);

  localparam int ROWS = (BUFFER_BYTES + 7) / 8;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [POS_W-1:0]   pos_r;
  logic [2:0]         off_r;
  logic [OP_W-1:0]    op_r;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_value_r;
  logic [BITS_W-1:0]  out_bits_r;

  logic               accept;
  logic               exec_done;
  logic               wr_en;
  logic [POS_W-4:0]   row_a;
  logic [POS_W-3:0]   row_b;
  logic [RAW-1:0]     rd_row_a;
  logic [RAW-1:0]     rd_row_b;
  logic [ROW_W-1:0]   rd_data_a;
  logic [ROW_W-1:0]   rd_data_b;
  exec_res_t          res;

  assign accept = in_valid && in_ready;

  assign wr_en = accept && (op_t'(in_operation) == OP_LOAD)
              && ({20'b0, in_byte_address} < 32'(BUFFER_BYTES));

  // rows past the store only feed bits beyond the length, which are masked
  assign row_a    = pos_r[POS_W-1:3];
  assign row_b    = {1'b0, row_a} + 11'd1;
  assign rd_row_a = ({22'b0, row_a} < 32'(ROWS)) ? RAW'(row_a) : '0;
  assign rd_row_b = ({21'b0, row_b} < 32'(ROWS)) ? RAW'(row_b) : '0;

  msbr_store #(
    .ROWS (ROWS),
    .RAW  (RAW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_row    (RAW'(in_byte_address[ADDR_W-1:3])),
    .wr_lane   (in_byte_address[2:0]),
    .wr_data   (in_byte_value),
    .rd_en     (accept),
    .rd_row_a  (rd_row_a),
    .rd_row_b  (rd_row_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  msbr_exec #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_exec (
    .op      (op_t'(op_r)),
    .count   (count_r),
    .pos     (pos_r),
    .off     (off_r),
    .len_raw (len_r),
    .row_a   (rd_data_a),
    .row_b   (rd_data_b),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    exec_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          exec_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (exec_done) begin
        pos_r       <= res.pos;
        off_r       <= res.off;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      count_r <= in_bit_count;
    end
    if (exec_done) begin
      out_value_r <= res.field_value;
      out_bits_r  <= {res.pos, res.off};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_value   = out_value_r;
  assign out_bits_consumed = out_bits_r;

endmodule
